@@ rtl/i2a_pkg.sv @@
// ----------------------------------------------------------------------------
// i2a_pkg: integer to ascii field formatter package
// shared word types, codes, character constants and the digit control bundle
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int VAL_W      = 64;
  localparam int FW_W       = 7;
  localparam int CH_W       = 7;
  localparam int MAX_WIDTH  = 64;
  localparam int DEC_DIGITS = 20;
  localparam int HEX_DIGITS = VAL_W / 4;
  localparam int DIG_W      = DEC_DIGITS * 4;
  localparam int NDIG_W     = $clog2(DEC_DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(VAL_W);

  typedef enum logic [1:0] {
    CMD_SDEC = 2'd0,
    CMD_UDEC = 2'd1,
    CMD_HEXL = 2'd2,
    CMD_HEXU = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SZ_32 = 2'd0,
    SZ_8  = 2'd1,
    SZ_16 = 2'd2,
    SZ_64 = 2'd3
  } size_t_t;

  localparam logic [CH_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CH_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 7'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CH_W-1:0] CH_LX    = 7'h78;
  localparam logic [CH_W-1:0] CH_UX    = 7'h58;
  localparam logic [CH_W-1:0] CH_LA    = 7'h61;
  localparam logic [CH_W-1:0] CH_UA    = 7'h41;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [1:0]       command;
    logic [1:0]       size_code;
    logic             alt_prefix;
    logic             plus_sign;
    logic             space_sign;
    logic             left_justify;
    logic             zero_pad;
    logic [FW_W-1:0]  field_width;
  } i2a_in_t;

  typedef struct packed {
    logic [CH_W-1:0] char_out;
    logic            last_char;
  } i2a_out_t;

  typedef struct packed {
    logic load_dec;
    logic load_hex;
    logic dabble;
    logic shift;
  } i2a_dig_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_NORM,
    ST_PAD_SP,
    ST_SIGN,
    ST_PAD_ZERO,
    ST_PFX0,
    ST_PFXX,
    ST_DIGIT,
    ST_PAD_POST
  } st_t;

  function automatic logic [CH_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CH_W-1:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {3'b000, d};
    end else begin
      digit_char = base + {3'b000, d} - 7'd10;
    end
  endfunction

endpackage

@@ rtl/i2a_digits.sv @@
// ----------------------------------------------------------------------------
// i2a_digits: digit shift register
// bit-serial binary to bcd (shift and add three) and nibble-wise digit shifting
// ----------------------------------------------------------------------------
module i2a_digits (
  input  logic                     clk,
  input  i2a_pkg::i2a_dig_ctl_t    ctl,
  input  logic [i2a_pkg::VAL_W-1:0] load_val,
  output logic [3:0]               top_digit
);
  import i2a_pkg::*;

  logic [VAL_W-1:0] bin_r, bin_nxt;
  logic [DIG_W-1:0] bcd_r, bcd_nxt;
  logic [DIG_W-1:0] adj;

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3 : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctl.load_dec) begin
      bin_nxt = load_val;
      bcd_nxt = '0;
    end else if (ctl.load_hex) begin
      bcd_nxt = {load_val, {(DIG_W-VAL_W){1'b0}}};
    end else if (ctl.dabble) begin
      bcd_nxt = {adj[DIG_W-2:0], bin_r[VAL_W-1]};
      bin_nxt = {bin_r[VAL_W-2:0], 1'b0};
    end else if (ctl.shift) begin
      bcd_nxt = {bcd_r[DIG_W-5:0], 4'b0000};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[DIG_W-1 -: 4];

endmodule

@@ rtl/integer_to_ascii_field_formatter.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_field_formatter
// renders one integer request as a padded ascii field, one character per word
//
//   channel  dir  handshake          word
//   in_      in   in_valid/in_stall  i2a_in_t  (operand, kind, size, flags, width)
//   out_     out  out_valid/out_stall i2a_out_t (char_out, last_char)
//
// decimal: accept, then the shift-and-add-three dabble loop, then normalise (drop leading
// zero digits); hex: accept, then normalise; then each field segment in turn, an empty
// segment being skipped, and the characters of each non-empty one
// decimal uses the 64-step shift-and-add-three loop; one character per cycle unless out_stall
// in_stall stays high from accept until every character is in the output register
// and the control is back in idle
// reset (rst_n low, synchronous) empties the output register and returns to idle
// out_stall holds the output register and pauses character generation
// ----------------------------------------------------------------------------
module integer_to_ascii_field_formatter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  i2a_pkg::i2a_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output i2a_pkg::i2a_out_t out_data
);
  import i2a_pkg::*;

  st_t state_r, state_nxt, succ_st;

  logic                 accept;
  logic                 is_sdec, neg;
  logic [VAL_W-1:0]     vt, mag;
  logic [FW_W-1:0]      width_c;

  logic                 upper_r, left_r, zpad_r, has_sign_r, pfx_r;
  logic [CH_W-1:0]      sign_ch_r;
  logic [FW_W-1:0]      width_r;
  logic [NDIG_W-1:0]    ndig_r, ndig_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [FW_W-1:0]      cnt_r, cnt_nxt;
  logic [FW_W-1:0]      rem_r, rem_nxt;
  logic [FW_W-1:0]      pad_r, pad_c, pad_use, total_c, succ_cnt;

  logic                 out_valid_r, out_valid_nxt;
  i2a_out_t             out_data_r, out_data_nxt;

  i2a_dig_ctl_t         dig_ctl;
  logic [3:0]           top_digit;
  logic                 out_free, is_emit, fire, advance, norm_more;
  logic [CH_W-1:0]      ch_c;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // operand truncation, sign extension and magnitude
  always_comb begin
    is_sdec = (in_data.command == CMD_SDEC);
    unique case (size_t_t'(in_data.size_code))
      SZ_8:    vt = {{(VAL_W-8){is_sdec && in_data.value[7]}}, in_data.value[7:0]};
      SZ_16:   vt = {{(VAL_W-16){is_sdec && in_data.value[15]}}, in_data.value[15:0]};
      SZ_32:   vt = {{(VAL_W-32){is_sdec && in_data.value[31]}}, in_data.value[31:0]};
      default: vt = in_data.value;
    endcase
    neg     = is_sdec && vt[VAL_W-1];
    mag     = neg ? (~vt + VAL_W'(1)) : vt;
    width_c = (in_data.field_width > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : in_data.field_width;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      upper_r <= (in_data.command == CMD_HEXU);
      left_r  <= in_data.left_justify;
      zpad_r  <= in_data.zero_pad;
      width_r <= width_c;
      pfx_r   <= in_data.command[1] && in_data.alt_prefix && (vt != '0);
      if (!in_data.command[1] && (neg || in_data.plus_sign || in_data.space_sign)) begin
        has_sign_r <= 1'b1;
      end else begin
        has_sign_r <= 1'b0;
      end
      sign_ch_r <= neg ? CH_MINUS : (in_data.plus_sign ? CH_PLUS : CH_SPACE);
    end
  end

  // field sizing
  always_comb begin
    total_c = FW_W'(ndig_r) + (pfx_r ? FW_W'(2) : FW_W'(0)) + FW_W'(has_sign_r);
    pad_c   = (width_r > total_c) ? width_r - total_c : '0;
    pad_use = (state_r == ST_NORM) ? pad_c : pad_r;
  end

  always_comb begin
    unique case (state_r)
      ST_NORM:     succ_st = ST_PAD_SP;
      ST_PAD_SP:   succ_st = ST_SIGN;
      ST_SIGN:     succ_st = ST_PAD_ZERO;
      ST_PAD_ZERO: succ_st = ST_PFX0;
      ST_PFX0:     succ_st = ST_PFXX;
      ST_PFXX:     succ_st = ST_DIGIT;
      ST_DIGIT:    succ_st = ST_PAD_POST;
      default:     succ_st = ST_IDLE;
    endcase
    unique case (succ_st)
      ST_PAD_SP:   succ_cnt = (!left_r && !zpad_r) ? pad_use : '0;
      ST_SIGN:     succ_cnt = FW_W'(has_sign_r);
      ST_PAD_ZERO: succ_cnt = (!left_r && zpad_r) ? pad_use : '0;
      ST_PFX0:     succ_cnt = FW_W'(pfx_r);
      ST_PFXX:     succ_cnt = FW_W'(pfx_r);
      ST_DIGIT:    succ_cnt = FW_W'(ndig_r);
      ST_PAD_POST: succ_cnt = left_r ? pad_use : '0;
      default:     succ_cnt = '0;
    endcase
  end

  assign is_emit   = (state_r inside {ST_PAD_SP, ST_SIGN, ST_PAD_ZERO, ST_PFX0, ST_PFXX,
                                      ST_DIGIT, ST_PAD_POST});
  assign fire      = is_emit && (cnt_r != '0) && out_free;
  assign advance   = (cnt_r == '0) || (fire && (cnt_r == FW_W'(1)));
  assign norm_more = (top_digit == 4'd0) && (ndig_r > NDIG_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_data.command[1] ? ST_NORM : ST_DABBLE;
        end
      end
      ST_DABBLE: begin
        if (bit_cnt_r == BIT_CNT_W'(VAL_W-1)) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (!norm_more) begin
          state_nxt = succ_st;
        end
      end
      default: begin
        if (advance) begin
          state_nxt = succ_st;
        end
      end
    endcase
  end

  // outputs and datapath control
  always_comb begin
    dig_ctl       = '0;
    ndig_nxt      = ndig_r;
    bit_cnt_nxt   = bit_cnt_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    ch_c          = CH_SPACE;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          dig_ctl.load_dec = !in_data.command[1];
          dig_ctl.load_hex = in_data.command[1];
          ndig_nxt         = in_data.command[1] ? NDIG_W'(HEX_DIGITS) : NDIG_W'(DEC_DIGITS);
          bit_cnt_nxt      = '0;
        end
      end
      ST_DABBLE: begin
        dig_ctl.dabble = 1'b1;
        bit_cnt_nxt    = bit_cnt_r + BIT_CNT_W'(1);
      end
      ST_NORM: begin
        if (norm_more) begin
          dig_ctl.shift = 1'b1;
          ndig_nxt      = ndig_r - NDIG_W'(1);
        end else begin
          cnt_nxt = succ_cnt;
          rem_nxt = pad_c + total_c;
        end
      end
      ST_SIGN:     ch_c = sign_ch_r;
      ST_PAD_ZERO: ch_c = CH_ZERO;
      ST_PFX0:     ch_c = CH_ZERO;
      ST_PFXX:     ch_c = upper_r ? CH_UX : CH_LX;
      ST_DIGIT:    ch_c = digit_char(top_digit, upper_r);
      default:     ch_c = CH_SPACE;
    endcase
    if (is_emit) begin
      if (fire) begin
        cnt_nxt                = cnt_r - FW_W'(1);
        rem_nxt                = rem_r - FW_W'(1);
        out_valid_nxt          = 1'b1;
        out_data_nxt.char_out  = ch_c;
        out_data_nxt.last_char = (rem_r == FW_W'(1));
        dig_ctl.shift          = (state_r == ST_DIGIT);
      end
      if (advance) begin
        cnt_nxt = succ_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
      cnt_r       <= '0;
      ndig_r      <= '0;
      bit_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
      cnt_r       <= cnt_nxt;
      ndig_r      <= ndig_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (state_r == ST_NORM) begin
      pad_r <= pad_c;
    end
  end

  i2a_digits u_digits (
    .clk       (clk),
    .ctl       (dig_ctl),
    .load_val  (mag),
    .top_digit (top_digit)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_DABBLE || state_r == ST_NORM))
    else $error("accepted word did not start conversion");

  a_idle_all_sent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (rem_r == '0))
    else $error("idle with characters still owed");

  a_fire_has_rem: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (rem_r != '0))
    else $error("character emitted beyond field length");

  a_norm_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NORM) |-> (ndig_r != '0))
    else $error("digit count ran out during normalise");
`endif

endmodule
